[design/tia_pkg.sv]
// ============================================================================
// tia_pkg: shared types and constants of the triangle index assembler
// Transfer payloads, configuration set, queue job format and register codes.
// ============================================================================
package tia_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ASSEMBLY_MODE = 2'd0;
  localparam logic [1:0] REG_INDEX_FORMAT  = 2'd1;
  localparam logic [1:0] REG_VERTEX_BASE   = 2'd2;
  localparam logic [1:0] REG_VERTEX_LIMIT  = 2'd3;

  // Assembly modes.
  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  // Raw index encodings.
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_S16 = 3'd2;
  localparam logic [2:0] FMT_U16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input transfer payload.
  typedef struct packed {
    logic [31:0] raw_index;
    logic        starts_primitive;
  } idx_item_t;

  // Output transfer payload.
  typedef struct packed {
    logic [31:0] vertex_index;
    logic [1:0]  corner;
    logic        run_last;
    logic        bad_index;
  } tri_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [1:0]  assembly_mode;
    logic [2:0]  index_format;
    logic [31:0] vertex_base;
    logic [31:0] vertex_limit;
  } tia_cfg_t;

  // One classified input: up to three corners, emitted in order by the back.
  typedef struct packed {
    logic [2:0][31:0] vert;
    logic [1:0]       last_step;
    logic [1:0]       corner_base;
    logic             bad;
  } tia_job_t;

endpackage

[design/tia_front.sv]
// ============================================================================
// tia_front: index classification and primitive history
// Extends and checks each raw index, tracks strip and fan history and pushes
// one job per input that causes results.
// ============================================================================
module tia_front #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  tia_pkg::tia_cfg_t  cfg,
  input  logic               idx_valid,
  output logic               idx_stall,
  input  tia_pkg::idx_item_t idx_data,
  input  logic               queue_full,
  output logic               push,
  output tia_pkg::tia_job_t  push_job
);
  import tia_pkg::*;

  logic [INDEX_WIDTH-1:0] first_held, prev_held, prev_prev_held;
  logic [INDEX_WIDTH-1:0] first_held_next, prev_held_next, prev_prev_held_next;
  logic [1:0]             seen_count, seen_count_next;
  logic                   odd_triangle, odd_triangle_next;
  logic                   error_latched, error_latched_next;

  logic                   accept;
  logic [31:0]            raw_masked;
  logic [31:0]            ext_value;
  logic                   neg;
  logic                   bad;
  logic [INDEX_WIDTH-1:0] cur;
  logic [1:0]             list_corner;

  // The input side stalls only while the queue has no room.
  assign idx_stall = queue_full;
  assign accept    = idx_valid && !queue_full;

  // Drop bits above the index width, then apply the selected encoding.
  assign raw_masked = 32'(idx_data.raw_index[INDEX_WIDTH-1:0]);

  always_comb begin
    ext_value = raw_masked;
    neg       = 1'b0;
    case (cfg.index_format)
      FMT_S8: begin
        ext_value = {24'd0, raw_masked[7:0]};
        neg       = raw_masked[7];
      end
      FMT_U8: begin
        ext_value = {24'd0, raw_masked[7:0]};
      end
      FMT_S16: begin
        ext_value = {16'd0, raw_masked[15:0]};
        neg       = raw_masked[15];
      end
      FMT_U16: begin
        ext_value = {16'd0, raw_masked[15:0]};
      end
      FMT_S32: begin
        neg = raw_masked[31];
      end
      default: begin
        ext_value = raw_masked;
      end
    endcase
  end

  assign bad = neg || (ext_value >= cfg.vertex_limit);
  assign cur = ext_value[INDEX_WIDTH-1:0];

  // Classification and history update for one accepted index.
  always_comb begin
    logic [INDEX_WIDTH-1:0] f, p, pp;
    logic [1:0]             sc;
    logic                   odd, err;
    f  = first_held;
    p  = prev_held;
    pp = prev_prev_held;
    sc = seen_count;
    odd = odd_triangle;
    err = error_latched;
    if (idx_data.starts_primitive) begin
      f   = '0;
      p   = '0;
      pp  = '0;
      sc  = 2'd0;
      odd = 1'b0;
      err = 1'b0;
    end

    first_held_next     = f;
    prev_held_next      = p;
    prev_prev_held_next = pp;
    seen_count_next     = sc;
    odd_triangle_next   = odd;
    error_latched_next  = err;
    list_corner         = (sc > 2'd2) ? 2'd0 : sc;

    push                 = 1'b0;
    push_job.vert        = '0;
    push_job.last_step   = 2'd0;
    push_job.corner_base = 2'd0;
    push_job.bad         = 1'b0;

    if (!err) begin
      if (bad) begin
        // Out of range: one error result, then silence until a new primitive.
        push               = 1'b1;
        push_job.bad       = 1'b1;
        error_latched_next = 1'b1;
      end else if (cfg.assembly_mode == MODE_LIST) begin
        push                 = 1'b1;
        push_job.vert[0]     = 32'(cur);
        push_job.corner_base = list_corner;
        seen_count_next      = (list_corner >= 2'd2) ? 2'd0 : list_corner + 2'd1;
      end else begin
        if (sc >= 2'd2) begin
          if (cfg.assembly_mode == MODE_STRIP) begin
            push               = 1'b1;
            push_job.last_step = 2'd2;
            push_job.vert[0]   = 32'(pp);
            push_job.vert[1]   = odd ? 32'(cur) : 32'(p);
            push_job.vert[2]   = odd ? 32'(p) : 32'(cur);
            odd_triangle_next  = !odd;
          end else if (cfg.assembly_mode == MODE_FAN) begin
            push               = 1'b1;
            push_job.last_step = 2'd2;
            push_job.vert[0]   = 32'(f);
            push_job.vert[1]   = 32'(p);
            push_job.vert[2]   = 32'(cur);
          end
        end
        if (sc == 2'd0) begin
          first_held_next = cur;
        end
        prev_prev_held_next = p;
        prev_held_next      = cur;
        seen_count_next     = (sc < 2'd2) ? sc + 2'd1 : 2'd2;
      end
    end
    push = push && accept;
  end

  // History registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_held     <= '0;
      prev_held      <= '0;
      prev_prev_held <= '0;
      seen_count     <= 2'd0;
      odd_triangle   <= 1'b0;
      error_latched  <= 1'b0;
    end else if (accept) begin
      first_held     <= first_held_next;
      prev_held      <= prev_held_next;
      prev_prev_held <= prev_prev_held_next;
      seen_count     <= seen_count_next;
      odd_triangle   <= odd_triangle_next;
      error_latched  <= error_latched_next;
    end
  end

endmodule

[design/tia_queue.sv]
// ============================================================================
// tia_queue: job queue between front and back
// A short first-in first-out buffer with its head visible to the reader.
// ============================================================================
module tia_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tia_pkg::tia_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tia_pkg::tia_job_t head_job
);
  import tia_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  tia_job_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fill;

  assign full       = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[design/tia_back.sv]
// ============================================================================
// tia_back: corner emitter
// Walks the corners of the queue head one per cycle while tri_stall is low, adds the vertex base and
// holds each result in the output register until it is taken.
// ============================================================================
module tia_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        vertex_base,
  input  logic               head_valid,
  input  tia_pkg::tia_job_t  head_job,
  output logic               pop,
  output logic               tri_valid,
  input  logic               tri_stall,
  output tia_pkg::tri_item_t tri_data
);
  import tia_pkg::*;

  logic [1:0] step;
  logic       load;
  logic       at_last;

  assign load    = !tri_valid || !tri_stall;
  assign at_last = (step == head_job.last_step);
  assign pop     = load && head_valid && at_last;

  // Step counter over the corners of the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      tri_valid <= 1'b0;
    end else if (load) begin
      tri_valid <= head_valid;
      if (head_valid) begin
        step <= at_last ? 2'd0 : step + 2'd1;
      end
    end
  end

  // Output register: one corner per transfer.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      tri_data.vertex_index <= head_job.bad ? 32'd0 : head_job.vert[step] + vertex_base;
      tri_data.corner       <= head_job.corner_base + step;
      tri_data.run_last     <= at_last;
      tri_data.bad_index    <= head_job.bad;
    end
  end

endmodule

[design/triangle_index_assembler.sv]
// ============================================================================
// triangle_index_assembler: mesh index stream to triangle list
// Top level with configuration registers, front classifier, queue and back.
// ============================================================================
// Usage: raw indices arrive on the idx channel (valid/stall); each is extended
// per index_format, checked against vertex_limit and turned into triangle list
// corners on the tri channel (valid/stall), each offset by vertex_base.
// List mode gives one corner per index; strip and fan modes give three corners
// per index from the third index of a primitive on. A bad index gives one
// result with bad_index set, and the primitive stays silent until the next
// index with starts_primitive set.
// The first result of an index passes through the queue slot and then the
// output register before it is presented on the tri channel.
// The back gives one result per cycle while tri_stall is low, set by the
// single output register; an index causing three corners holds the back for
// all three, so strip and fan streams take indices slower than list streams.
// A two-entry job queue lets the front keep taking indices while the back
// works or the receiver stalls; idx_stall rises only when that queue is full.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not enforce it.
// Synchronous reset clears history, queue and output valid and resets registers.
// ============================================================================
module triangle_index_assembler #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               idx_valid,
  output logic               idx_stall,
  input  tia_pkg::idx_item_t idx_data,
  output logic               tri_valid,
  input  logic               tri_stall,
  output tia_pkg::tri_item_t tri_data
);
  import tia_pkg::*;

  tia_cfg_t cfg;
  logic     push, pop, queue_full, head_valid;
  tia_job_t push_job, head_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.assembly_mode <= MODE_LIST;
      cfg.index_format  <= FMT_U32;
      cfg.vertex_base   <= 32'd0;
      cfg.vertex_limit  <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ASSEMBLY_MODE: cfg.assembly_mode <= cfg_data[1:0];
        REG_INDEX_FORMAT:  cfg.index_format  <= cfg_data[2:0];
        REG_VERTEX_BASE:   cfg.vertex_base   <= cfg_data;
        REG_VERTEX_LIMIT:  cfg.vertex_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify indices and keep primitive history.
  tia_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .idx_valid (idx_valid),
    .idx_stall (idx_stall),
    .idx_data  (idx_data),
    .queue_full(queue_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Queue between front and back.
  tia_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // Back: emit corners one per cycle while tri_stall is low.
  tia_back u_back (
    .clk        (clk),
    .rst        (rst),
    .vertex_base(cfg.vertex_base),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .tri_valid  (tri_valid),
    .tri_stall  (tri_stall),
    .tri_data   (tri_data)
  );

endmodule

[sim/triangle_index_assembler_test.sv]
// ============================================================================
// triangle_index_assembler_test: self-checking bench for the index assembler
// A queue-fed driver sends raw indices and a monitor checks every triangle
// corner against a cycle-free prediction of list, strip and fan assembly,
// over many register settings and three patterns of idling on both sides.
// ============================================================================
module triangle_index_assembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tia_pkg::*;

  localparam int          IDX_W       = 32;
  localparam logic [31:0] IDX_MASK    = 32'hFFFF_FFFF >> (32 - IDX_W);
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [2:0]  FMT_SPARE_A = 3'd6;
  localparam logic [2:0]  FMT_SPARE_B = 3'd7;
  localparam int          RANDOM_ITEMS = 380;
  localparam int          DRAIN_BUDGET = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        idx_valid = 1'b0;
  logic        idx_stall;
  idx_item_t   idx_data = '0;
  logic        tri_valid;
  logic        tri_stall = 1'b0;
  tri_item_t   tri_data;

  // Stimulus and expectations.
  idx_item_t   index_backlog[$];
  tri_item_t   expected_corners[$];
  logic        idx_sent = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Bookkeeping for the summary.
  int          mismatches = 0;
  int          corners_checked = 0;
  int          indices_sent = 0;
  int          settings_applied = 0;

  // Predicted register contents.
  logic [1:0]  cfg_mode  = MODE_LIST;
  logic [2:0]  cfg_fmt   = FMT_U32;
  logic [31:0] cfg_base  = '0;
  logic [31:0] cfg_limit = '0;

  // Predicted assembly history.
  logic [31:0] hist_first = '0;
  logic [31:0] hist_prev  = '0;
  logic [31:0] hist_prev2 = '0;
  logic [1:0]  hist_count = '0;
  logic        strip_odd  = 1'b0;
  logic        prim_failed = 1'b0;

  triangle_index_assembler #(.INDEX_WIDTH(IDX_W)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .idx_valid (idx_valid),
    .idx_stall (idx_stall),
    .idx_data  (idx_data),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_data  (tri_data)
  );

  always #2 clk = ~clk;

  // Queue one offset corner of a valid index.
  task automatic emit_corner(logic [31:0] vert, logic [1:0] pos, logic last);
    expected_corners.push_back(tri_item_t'{vertex_index: vert + cfg_base, corner: pos,
                                           run_last: last, bad_index: 1'b0});
  endtask

  // Work out the corners caused by one accepted index.
  task automatic assemble_index(idx_item_t item);
    logic [31:0] kept;
    logic [31:0] cur;
    logic        neg;
    kept = item.raw_index & IDX_MASK;
    if (item.starts_primitive) begin
      hist_first  = '0;
      hist_prev   = '0;
      hist_prev2  = '0;
      hist_count  = '0;
      strip_odd   = 1'b0;
      prim_failed = 1'b0;
    end
    if (prim_failed) return;

    neg = 1'b0;
    case (cfg_fmt)
      FMT_S8:  begin cur = {24'd0, kept[7:0]};  neg = kept[7];  end
      FMT_U8:  cur = {24'd0, kept[7:0]};
      FMT_S16: begin cur = {16'd0, kept[15:0]}; neg = kept[15]; end
      FMT_U16: cur = {16'd0, kept[15:0]};
      FMT_S32: begin cur = kept; neg = kept[31]; end
      default: cur = kept;
    endcase

    // An out-of-range index reports once and silences the primitive.
    if (neg || cur >= cfg_limit) begin
      prim_failed = 1'b1;
      expected_corners.push_back(tri_item_t'{vertex_index: '0, corner: 2'd0,
                                             run_last: 1'b1, bad_index: 1'b1});
      return;
    end

    case (cfg_mode)
      MODE_LIST: begin
        if (hist_count > 2'd2) hist_count = 2'd0;
        emit_corner(cur, hist_count, 1'b1);
        hist_count = (hist_count >= 2'd2) ? 2'd0 : hist_count + 2'd1;
        return;
      end
      MODE_STRIP: begin
        if (hist_count >= 2'd2) begin
          emit_corner(hist_prev2, 2'd0, 1'b0);
          // Odd triangles swap the last two corners to keep the winding.
          if (strip_odd) begin
            emit_corner(cur, 2'd1, 1'b0);
            emit_corner(hist_prev, 2'd2, 1'b1);
          end else begin
            emit_corner(hist_prev, 2'd1, 1'b0);
            emit_corner(cur, 2'd2, 1'b1);
          end
          strip_odd = ~strip_odd;
        end
      end
      MODE_FAN: begin
        if (hist_count >= 2'd2) begin
          emit_corner(hist_first, 2'd0, 1'b0);
          emit_corner(hist_prev, 2'd1, 1'b0);
          emit_corner(cur, 2'd2, 1'b1);
        end
      end
      default: ;
    endcase

    // Shift the history; the unused mode updates it without output.
    if (hist_count == 2'd0) hist_first = cur;
    hist_prev2 = hist_prev;
    hist_prev  = cur;
    if (hist_count < 2'd2) hist_count = hist_count + 2'd1;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: a new transfer is offered only after the previous one went.
  always @(negedge clk) begin
    if (rst) begin
      idx_valid <= 1'b0;
    end else if (!idx_valid || idx_sent) begin
      if (index_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        idx_data  <= index_backlog.pop_front();
        idx_valid <= 1'b1;
      end else begin
        idx_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    tri_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    idx_sent <= !rst && idx_valid && !idx_stall;
    if (!rst && idx_valid && !idx_stall) begin
      assemble_index(idx_data);
      indices_sent++;
    end
    if (!rst && tri_valid && !tri_stall) begin
      if (expected_corners.size() == 0) begin
        $error("unexpected corner: vertex_index 0x%08h corner %0d run_last %0b bad_index %0b",
               tri_data.vertex_index, tri_data.corner, tri_data.run_last,
               tri_data.bad_index);
        mismatches++;
      end else begin
        tri_item_t want;
        want = expected_corners.pop_front();
        check_field("vertex_index", want.vertex_index, tri_data.vertex_index);
        check_field("corner", 32'(want.corner), 32'(tri_data.corner));
        check_field("run_last", 32'(want.run_last), 32'(tri_data.run_last));
        check_field("bad_index", 32'(want.bad_index), 32'(tri_data.bad_index));
        corners_checked++;
      end
    end
  end

  task automatic queue_index(logic [31:0] raw, logic start);
    index_backlog.push_back(idx_item_t'{raw_index: raw, starts_primitive: start});
  endtask

  // Wait until every transfer is done, then cover indices that give no corner.
  task automatic drain();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((index_backlog.size() > 0 || idx_valid || expected_corners.size() > 0) &&
               waited < DRAIN_BUDGET);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers while the block is idle.
  task automatic apply_settings(logic [1:0] mode, logic [2:0] fmt,
                                logic [31:0] base, logic [31:0] limit);
    logic [31:0] word;
    word = $urandom;
    word[1:0] = mode;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ASSEMBLY_MODE;
    cfg_data  <= word;
    word = $urandom;
    word[2:0] = fmt;
    @(negedge clk);
    cfg_index <= REG_INDEX_FORMAT;
    cfg_data  <= word;
    @(negedge clk);
    cfg_index <= REG_VERTEX_BASE;
    cfg_data  <= base;
    @(negedge clk);
    cfg_index <= REG_VERTEX_LIMIT;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_mode  = mode;
    cfg_fmt   = fmt;
    cfg_base  = base;
    cfg_limit = limit;
    settings_applied++;
    @(posedge clk);
  endtask

  // A raw index that is in range for the format and limit, with junk above.
  function automatic logic [31:0] good_raw(logic [2:0] fmt, logic [31:0] limit);
    longint unsigned span;
    longint unsigned cap;
    logic [31:0]     field;
    logic [31:0]     val;
    case (fmt)
      FMT_S8:  begin span = 64'd128;   field = 32'h0000_00FF; end
      FMT_U8:  begin span = 64'd256;   field = 32'h0000_00FF; end
      FMT_S16: begin span = 64'd32768; field = 32'h0000_FFFF; end
      FMT_U16: begin span = 64'd65536; field = 32'h0000_FFFF; end
      FMT_S32: begin span = 64'h8000_0000;   field = 32'hFFFF_FFFF; end
      default: begin span = 64'h1_0000_0000; field = 32'hFFFF_FFFF; end
    endcase
    cap = (limit < span) ? limit : span;
    if (cap == 0) return $urandom;
    val = 32'($urandom % cap);
    return ($urandom & ~field) | val;
  endfunction

  initial begin : stimulus
    int          random_sent;
    int          seg_len;
    int          seg_count;
    int          prim_len;
    int          roll;
    logic [1:0]  mode;
    logic [2:0]  fmt;
    logic [31:0] base;
    logic [31:0] limit;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 13;
    recv_idle_pct = 87;

    // Reset settings: a zero vertex count makes every index bad.
    queue_index(32'd0, 1'b1);
    queue_index(32'd3, 1'b0);
    queue_index(32'hFFFF_FFFF, 1'b1);
    drain();

    // List mode at the top of the range; the base wraps around.
    apply_settings(MODE_LIST, FMT_U32, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    queue_index(32'd0, 1'b1);
    queue_index(32'hFFFF_FFFE, 1'b0);
    queue_index(32'h0000_0011, 1'b0);
    queue_index(32'hFFFF_FFFF, 1'b0);
    queue_index(32'd5, 1'b0);
    drain();

    // Strip with alternating winding, junk upper bits, then a negative s8.
    apply_settings(MODE_STRIP, FMT_S8, 32'd100, 32'd200);
    queue_index(32'h0000_0010, 1'b1);
    queue_index(32'hABCD_EF20, 1'b0);
    queue_index(32'h0000_0030, 1'b0);
    queue_index(32'h0000_0040, 1'b0);
    queue_index(32'h0000_007F, 1'b0);
    queue_index(32'h0000_0085, 1'b0);
    queue_index(32'h0000_0001, 1'b0);
    queue_index(32'h0000_0002, 1'b1);
    drain();

    // Fan with the largest positive s16 and then a negative one.
    apply_settings(MODE_FAN, FMT_S16, 32'h8000_0000, 32'd40000);
    queue_index(32'h1234_0005, 1'b1);
    queue_index(32'h0000_0006, 1'b0);
    queue_index(32'hFFFF_7FFF, 1'b0);
    queue_index(32'h0000_8000, 1'b0);
    drain();

    // The unused mode stays silent except for a bad index.
    apply_settings(MODE_UNUSED, FMT_U16, 32'd0, 32'h0000_FFFF);
    queue_index(32'h0000_0002, 1'b1);
    queue_index(32'hFFFF_0003, 1'b0);
    queue_index(32'h0000_FFFF, 1'b0);
    drain();

    // Signed 32-bit extremes.
    apply_settings(MODE_FAN, FMT_S32, 32'd0, 32'hFFFF_FFFF);
    queue_index(32'h7FFF_FFFE, 1'b1);
    queue_index(32'h8000_0000, 1'b0);
    drain();

    // The spare format codes read as unsigned 32-bit.
    apply_settings(MODE_STRIP, FMT_SPARE_B, 32'd7, 32'hFFFF_FFFF);
    queue_index(32'h8000_0000, 1'b1);
    queue_index(32'd1, 1'b0);
    queue_index(32'd2, 1'b0);
    drain();

    // Random segments: mostly well-formed primitives with some noise.
    random_sent = 0;
    seg_count = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 87;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      roll = $urandom_range(0, 9);
      mode = (roll < 3) ? MODE_LIST : (roll < 6) ? MODE_STRIP :
             (roll < 9) ? MODE_FAN : MODE_UNUSED;
      roll = $urandom_range(0, 13);
      fmt = (roll < 12) ? 3'(roll / 2) : (roll == 12) ? FMT_SPARE_A : FMT_SPARE_B;
      roll = $urandom_range(0, 3);
      base = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
      roll = $urandom_range(0, 11);
      case (roll)
        0:          limit = 32'd0;
        1, 2, 3:    limit = 32'hFFFF_FFFF;
        4, 5, 6, 7: limit = $urandom_range(1, 300);
        8, 9:       limit = $urandom;
        default:    limit = 32'd1 << (7 + 8 * $urandom_range(0, 3));
      endcase
      apply_settings(mode, fmt, base, limit);

      seg_len = $urandom_range(15, 45);
      seg_count = 0;
      while (seg_count < seg_len) begin
        prim_len = $urandom_range(1, 9);
        for (int k = 0; k < prim_len; k++) begin
          roll = $urandom_range(0, 19);
          if (roll < 2) begin
            queue_index($urandom, 1'($urandom));
          end else begin
            queue_index(good_raw(fmt, limit), k == 0 && roll != 2);
          end
          seg_count++;
        end
      end
      random_sent += seg_count;
      drain();
    end

    repeat (20) @(posedge clk);
    if (expected_corners.size() > 0) begin
      $error("%0d expected corners never arrived", expected_corners.size());
      mismatches++;
    end

    $display("Sent %0d indices under %0d register settings in list, strip and fan modes,",
             indices_sent, settings_applied);
    $display("and compared %0d corners, with %0d mismatches.", corners_checked, mismatches);
    if (mismatches == 0) begin
      $display("[triangle_index_assembler] OK");
    end else begin
      $display("[triangle_index_assembler] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("[triangle_index_assembler] ERROR");
    $finish;
  end

endmodule

[files.f]
design/tia_pkg.sv
design/tia_front.sv
design/tia_queue.sv
design/tia_back.sv
design/triangle_index_assembler.sv
sim/triangle_index_assembler_test.sv
